// File: rtl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// No dependencies; every other file refers to this package by scoped names.
package ffha_pkg;

  // Default geometry, handed to the top-level parameters
  localparam int unsigned HEAP_BYTES_DEF   = 4096;
  localparam int unsigned HEADER_BYTES_DEF = 16;

  // Fixed field widths
  localparam int unsigned OP_W     = 1;
  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned ADDR_W   = 13;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO         = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_MEMORY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREE_IGNORED = 3'd4;

  // Register index, taken from paddr[2]
  localparam logic REG_SPLIT_THR = 1'b0;
  localparam logic REG_MAX_REQ   = 1'b1;

  // Register reset values
  localparam logic [SIZE_W-1:0] SPLIT_THR_RST = 12'd32;
  localparam logic [SIZE_W-1:0] MAX_REQ_RST   = 12'd4095;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a request
    S_WALK,   // issue header read, or append at heap end
    S_EVAL,   // header data back: take, or step to next block
    S_SPLIT,  // write the split-off remainder header
    S_HOLD    // result waits for the output register
  } state_t;

endpackage

// File: rtl/ffha_if.sv
// Request and result channel interfaces of the heap allocator.
// Depends on ffha_pkg for field widths.
interface ffha_req_if;
  logic                             valid;
  logic                             ready;
  logic [ffha_pkg::OP_W-1:0]        op;
  logic [ffha_pkg::SIZE_W-1:0]      req_size;
  logic [ffha_pkg::ADDR_W-1:0]      free_addr;

  modport source (output valid, op, req_size, free_addr, input ready);
  modport sink   (input valid, op, req_size, free_addr, output ready);
endinterface

interface ffha_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [ffha_pkg::STATUS_W-1:0]    status;
  logic [ffha_pkg::ADDR_W-1:0]      payload_addr;

  modport source (output valid, status, payload_addr, input ready);
  modport sink   (input valid, status, payload_addr, output ready);
endinterface

// File: rtl/first_fit_heap_allocator.sv
// Free and rejected requests complete from idle; an empty-heap append completes in walk.
//   An allocate reads each header it walks (the taken one included) in walk and eval,
//   then appends, takes or splits; a busy output register parks the result in hold.
// One request at a time; the walk reads headers one after another through the
//   single read port of the header memories, so the rate follows occupancy.
// Reset (sync, rst_n low): heap_top to 0, registers to defaults, output empty.
//   Header memories are not cleared; the walk never reads an unwritten entry.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ffha_req_if.sink                      in_chan,
  ffha_rsp_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffha_pkg::CFG_AW-1:0]   paddr,
  input  logic [ffha_pkg::CFG_DW-1:0]   pwdata,
  output logic [ffha_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned SIZE_W = ffha_pkg::SIZE_W;
  localparam int unsigned ADDR_W = ffha_pkg::ADDR_W;
  localparam int unsigned ST_W   = ffha_pkg::STATUS_W;
  // memory index width
  localparam int unsigned AW = $clog2(HEAP_BYTES);
  // heap_top can equal HEAP_BYTES
  localparam int unsigned TW = $clog2(HEAP_BYTES + 1);
  // compute width: holds offset + header + size without wrap
  localparam int unsigned CW = ((TW > SIZE_W) ? TW : SIZE_W) + 2;

  localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);

  // ---------------------------------------------------------------
  // Configuration registers (APB, zero-wait)
  // ---------------------------------------------------------------
  logic [SIZE_W-1:0] thr_r;
  logic [SIZE_W-1:0] max_req_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= ffha_pkg::SPLIT_THR_RST;
      max_req_r <= ffha_pkg::MAX_REQ_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        ffha_pkg::REG_SPLIT_THR: thr_r     <= pwdata[SIZE_W-1:0];
        ffha_pkg::REG_MAX_REQ:   max_req_r <= pwdata[SIZE_W-1:0];
        default:                 ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      ffha_pkg::REG_SPLIT_THR: prdata = ffha_pkg::CFG_DW'(thr_r);
      ffha_pkg::REG_MAX_REQ:   prdata = ffha_pkg::CFG_DW'(max_req_r);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Header memories: payload size and allocated mark, one entry per
  // byte offset. One write and one registered read per cycle.
  // ---------------------------------------------------------------
  logic [SIZE_W-1:0] size_mem [HEAP_BYTES];
  logic              used_mem [HEAP_BYTES];

  logic              size_we;
  logic              used_we;
  logic [AW-1:0]     wr_addr;
  logic [SIZE_W-1:0] size_wd;
  logic              used_wd;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [SIZE_W-1:0] rd_size_r;
  logic              rd_used_r;

  always_ff @(posedge clk) begin
    if (size_we) size_mem[wr_addr] <= size_wd;
    if (used_we) used_mem[wr_addr] <= used_wd;
    if (rd_en) begin
      rd_size_r <= size_mem[rd_addr];
      rd_used_r <= used_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------
  ffha_pkg::state_t  state_r, state_nxt;
  logic [TW-1:0]     heap_top_r, heap_top_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;

  // result waiting for the output register
  logic [ST_W-1:0]   res_status_r;
  logic [ADDR_W-1:0] res_addr_r;

  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r;
  logic [ADDR_W-1:0] out_addr_r;

  logic              accept;
  logic              slot_free;
  logic              done;
  logic [ST_W-1:0]   done_status;
  logic [ADDR_W-1:0] done_addr;
  logic              go_walk;
  logic              go_split;

  // datapath terms
  logic [CW-1:0]     top_c;
  logic [CW-1:0]     req_c;
  logic [CW-1:0]     sz_c;
  logic [CW-1:0]     pos_hdr;     // payload offset of block at pos
  logic [CW-1:0]     rest_c;      // header offset of split remainder
  logic [CW-1:0]     top_hdr;     // payload offset of appended block
  logic [CW-1:0]     fa_c;
  logic [CW-1:0]     fh_c;
  logic              hit;
  logic              split;

  assign in_chan.ready = (state_r == ffha_pkg::S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign slot_free     = !out_valid_r || out_chan.ready;

  assign top_c   = CW'(heap_top_r);
  assign req_c   = CW'(req_r);
  assign sz_c    = CW'(rd_size_r);
  assign pos_hdr = pos_r + HDR_C;
  assign rest_c  = pos_hdr + req_c;
  assign top_hdr = top_c + HDR_C;
  assign fa_c    = CW'(in_chan.free_addr);
  assign fh_c    = fa_c - HDR_C;

  // first free block large enough; split only if the excess passes the
  // threshold and still holds a header
  assign hit   = !rd_used_r && (sz_c >= req_c);
  assign split = (sz_c > req_c + CW'(thr_r)) && (sz_c >= req_c + HDR_C);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffha_pkg::S_IDLE: begin
        if (go_walk)   state_nxt = ffha_pkg::S_WALK;
        else if (done) state_nxt = slot_free ? ffha_pkg::S_IDLE : ffha_pkg::S_HOLD;
      end
      ffha_pkg::S_WALK: begin
        if (done) state_nxt = slot_free ? ffha_pkg::S_IDLE : ffha_pkg::S_HOLD;
        else      state_nxt = ffha_pkg::S_EVAL;
      end
      ffha_pkg::S_EVAL: begin
        if (go_split)  state_nxt = ffha_pkg::S_SPLIT;
        else if (done) state_nxt = slot_free ? ffha_pkg::S_IDLE : ffha_pkg::S_HOLD;
        else           state_nxt = ffha_pkg::S_WALK;
      end
      ffha_pkg::S_SPLIT,
      ffha_pkg::S_HOLD: begin
        state_nxt = slot_free ? ffha_pkg::S_IDLE : ffha_pkg::S_HOLD;
      end
      default: state_nxt = ffha_pkg::S_IDLE;
    endcase
  end

  // datapath control and memory accesses
  always_comb begin
    done         = 1'b0;
    done_status  = ffha_pkg::ST_OK;
    done_addr    = '0;
    go_walk      = 1'b0;
    go_split     = 1'b0;
    size_we      = 1'b0;
    used_we      = 1'b0;
    wr_addr      = pos_r[AW-1:0];
    size_wd      = req_r;
    used_wd      = 1'b1;
    rd_en        = 1'b0;
    rd_addr      = pos_r[AW-1:0];
    pos_nxt      = pos_r;
    req_nxt      = req_r;
    heap_top_nxt = heap_top_r;

    unique case (state_r)
      ffha_pkg::S_IDLE: begin
        if (accept) begin
          if (in_chan.op == ffha_pkg::OP_FREE) begin
            done = 1'b1;
            // null, below the first header, or past the used heap
            if (fa_c < HDR_C || fh_c >= top_c || fh_c >= HEAP_C) begin
              done_status = ffha_pkg::ST_FREE_IGNORED;
            end else begin
              used_we = 1'b1;
              used_wd = 1'b0;
              wr_addr = fh_c[AW-1:0];
            end
          end else if (in_chan.req_size == '0) begin
            done        = 1'b1;
            done_status = ffha_pkg::ST_ZERO;
          end else if (in_chan.req_size > max_req_r) begin
            done        = 1'b1;
            done_status = ffha_pkg::ST_TOO_LARGE;
          end else begin
            go_walk = 1'b1;
            pos_nxt = '0;
            req_nxt = in_chan.req_size;
          end
        end
      end

      ffha_pkg::S_WALK: begin
        if (pos_r < top_c) begin
          rd_en = 1'b1;
        end else begin
          // walk found nothing: append at heap end, or report no memory
          done = 1'b1;
          if (HEAP_C - top_c < req_c + HDR_C) begin
            done_status = ffha_pkg::ST_NO_MEMORY;
          end else begin
            size_we      = 1'b1;
            used_we      = 1'b1;
            wr_addr      = heap_top_r[AW-1:0];
            heap_top_nxt = TW'(top_hdr + req_c);
            done_addr    = top_hdr[ADDR_W-1:0];
          end
        end
      end

      ffha_pkg::S_EVAL: begin
        if (hit) begin
          used_we = 1'b1;
          size_we = split;
          if (split && rest_c < HEAP_C) begin
            go_split = 1'b1;
          end else begin
            done      = 1'b1;
            done_addr = pos_hdr[ADDR_W-1:0];
          end
        end else begin
          pos_nxt = pos_hdr + sz_c;
        end
      end

      ffha_pkg::S_SPLIT: begin
        // remainder becomes a free block right after the taken payload
        size_we   = 1'b1;
        used_we   = 1'b1;
        used_wd   = 1'b0;
        wr_addr   = rest_c[AW-1:0];
        size_wd   = SIZE_W'(sz_c - req_c - HDR_C);
        done      = 1'b1;
        done_addr = pos_hdr[ADDR_W-1:0];
      end

      ffha_pkg::S_HOLD: begin
        done        = 1'b1;
        done_status = res_status_r;
        done_addr   = res_addr_r;
      end

      default: ;
    endcase
  end

  // output register: loads when free or being emptied this cycle
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done && slot_free)       out_valid_nxt = 1'b1;
    else if (out_chan.ready)     out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffha_pkg::S_IDLE;
      heap_top_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      heap_top_r  <= heap_top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    req_r <= req_nxt;
    if (done && !slot_free) begin
      res_status_r <= done_status;
      res_addr_r   <= done_addr;
    end
    if (done && slot_free) begin
      out_status_r <= done_status;
      out_addr_r   <= done_addr;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.payload_addr = out_addr_r;

endmodule

// File: sim/ffha_checker.sv
`timescale 1ns / 100ps
// Result checker for the first-fit heap allocator: mirrors the heap layout,
// predicts each result and compares it. Depends on ffha_pkg and ffha_if.
module ffha_checker #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ffha_req_if                         req_mon,
  ffha_rsp_if                         rsp_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ffha_pkg::CFG_AW-1:0] paddr,
  input  logic [ffha_pkg::CFG_DW-1:0] pwdata,
  output int unsigned                 mismatch_count,
  output int unsigned                 grants_pending
);

  typedef struct packed {
    logic [ffha_pkg::STATUS_W-1:0] status;
    logic [ffha_pkg::ADDR_W-1:0]   payload_addr;
  } grant_t;

  // Mirror of the heap: one header slot per byte offset
  bit [ffha_pkg::ADDR_W-1:0] blk_size  [HEAP_BYTES];
  bit                        blk_taken [HEAP_BYTES];
  int unsigned               used_top;
  int unsigned               split_margin;
  int unsigned               size_limit;
  grant_t                    grants_due [$];

  // Zero and too-large checks, then first-fit walk, split or append; updates the mirror
  function automatic grant_t alloc_outcome(input int unsigned want);
    grant_t      g;
    int unsigned pos;
    int unsigned sz;
    int unsigned rest;
    bit          placed;
    g.status       = ffha_pkg::ST_OK;
    g.payload_addr = '0;
    pos            = 0;
    placed         = 1'b0;
    if (want == 0) begin
      g.status = ffha_pkg::ST_ZERO;
    end else if (want > size_limit) begin
      g.status = ffha_pkg::ST_TOO_LARGE;
    end else begin
      while (!placed && pos < used_top && pos < HEAP_BYTES) begin
        sz = 32'(blk_size[pos]);
        if (!blk_taken[pos] && sz >= want) begin
          if (sz > want + split_margin && sz >= want + HEADER_BYTES) begin
            rest = pos + HEADER_BYTES + want;
            if (rest < HEAP_BYTES) begin
              blk_size[rest]  = ffha_pkg::ADDR_W'(sz - want - HEADER_BYTES);
              blk_taken[rest] = 1'b0;
            end
            blk_size[pos] = ffha_pkg::ADDR_W'(want);
          end
          blk_taken[pos] = 1'b1;
          g.payload_addr = ffha_pkg::ADDR_W'(pos + HEADER_BYTES);
          placed         = 1'b1;
        end else begin
          pos = pos + HEADER_BYTES + sz;
        end
      end
      if (!placed) begin
        if (HEAP_BYTES - used_top < want + HEADER_BYTES) begin
          g.status = ffha_pkg::ST_NO_MEMORY;
        end else begin
          blk_size[used_top]  = ffha_pkg::ADDR_W'(want);
          blk_taken[used_top] = 1'b1;
          g.payload_addr      = ffha_pkg::ADDR_W'(used_top + HEADER_BYTES);
          used_top            = used_top + HEADER_BYTES + want;
        end
      end
    end
    return g;
  endfunction

  // Clears the mark at addr - header if inside the used heap
  function automatic grant_t free_outcome(input int unsigned at);
    grant_t      g;
    int unsigned h;
    g.status       = ffha_pkg::ST_FREE_IGNORED;
    g.payload_addr = '0;
    if (at >= HEADER_BYTES) begin
      h = at - HEADER_BYTES;
      if (h < used_top && h < HEAP_BYTES) begin
        blk_taken[h] = 1'b0;
        g.status     = ffha_pkg::ST_OK;
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin : watch
    grant_t due;
    if (!rst_n) begin
      used_top       = 0;
      split_margin   = 32'(ffha_pkg::SPLIT_THR_RST);
      size_limit     = 32'(ffha_pkg::MAX_REQ_RST);
      mismatch_count = 0;
      grants_due.delete();
    end else begin
      // result side first: it belongs to an earlier request
      if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
        if (grants_due.size() == 0) begin
          $error("result with no request outstanding: status %0d payload_addr %0d",
                 rsp_mon.status, rsp_mon.payload_addr);
          mismatch_count++;
        end else begin
          due = grants_due.pop_front();
          if (rsp_mon.status !== due.status) begin
            $error("status mismatch: expected %0d, actual %0d", due.status, rsp_mon.status);
            mismatch_count++;
          end
          if (rsp_mon.payload_addr !== due.payload_addr) begin
            $error("payload_addr mismatch: expected %0d, actual %0d",
                   due.payload_addr, rsp_mon.payload_addr);
            mismatch_count++;
          end
        end
      end
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
        if (req_mon.op == ffha_pkg::OP_FREE)
          grants_due.push_back(free_outcome(32'(req_mon.free_addr)));
        else
          grants_due.push_back(alloc_outcome(32'(req_mon.req_size)));
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == ffha_pkg::REG_MAX_REQ)
          size_limit = 32'(pwdata[ffha_pkg::SIZE_W-1:0]);
        else
          split_margin = 32'(pwdata[ffha_pkg::SIZE_W-1:0]);
      end
    end
    grants_pending <= grants_due.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the first-fit heap allocator: clock, reset, request and
// register stimulus, result back-pressure, watchdog and verdict.
// Depends on ffha_pkg, ffha_if, first_fit_heap_allocator and ffha_checker.
module tb_top;

  // Longest legal quiet stretch is a full-heap walk plus both side gaps, and the
  // final drain waits a tail of DRAIN_TAIL; the limit sits well above both.
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_TAIL  = 600;
  localparam int unsigned CFG_SETTLE  = 2;
  localparam int          NUM_PHASES  = 6;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [ffha_pkg::CFG_AW-1:0] cfg_paddr;
  logic [ffha_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [ffha_pkg::CFG_DW-1:0] cfg_prdata;
  logic                        cfg_pready;
  int unsigned                 mismatch_count;
  int unsigned                 grants_pending;
  int unsigned                 stall_cycles;

  // Burst counters: while nonzero the side runs with no idle cycles
  int                src_run;
  int                sink_run;

  // Payload addresses handed out and not yet freed by the stimulus
  logic [ffha_pkg::ADDR_W-1:0] live_blocks [$];
  bit   [ffha_pkg::ADDR_W-1:0] recent_free;

  ffha_req_if req_chan ();
  ffha_rsp_if rsp_chan ();

  first_fit_heap_allocator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (rsp_chan),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready)
  );

  ffha_checker i_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_mon        (req_chan),
    .rsp_mon        (rsp_chan),
    .psel           (cfg_psel),
    .penable        (cfg_penable),
    .pwrite         (cfg_pwrite),
    .pready         (cfg_pready),
    .paddr          (cfg_paddr),
    .pwdata         (cfg_pwdata),
    .mismatch_count (mismatch_count),
    .grants_pending (grants_pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Idle cycles before the next transfer are drawn at random, with occasional
  // back-to-back bursts of 9..41 transfers.
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run_left = int'($urandom_range(8, 40));
      return 0;
    end
    return int'($urandom_range(0, 16));
  endfunction

  // valid stays high after acceptance; it only drops when a gap follows,
  // so a zero gap never lowers and raises it in the same step.
  task automatic send_request(input logic [ffha_pkg::OP_W-1:0]   op,
                              input logic [ffha_pkg::SIZE_W-1:0] nbytes,
                              input logic [ffha_pkg::ADDR_W-1:0] addr);
    int gap;
    gap = draw_wait(src_run);
    if (gap > 0) begin
      req_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_chan.valid     <= 1'b1;
    req_chan.op        <= op;
    req_chan.req_size  <= nbytes;
    req_chan.free_addr <= addr;
    do @(posedge clk); while (req_chan.ready !== 1'b1);
  endtask

  // Unused field of each request carries random junk
  task automatic request_alloc(input logic [ffha_pkg::SIZE_W-1:0] nbytes);
    send_request(ffha_pkg::OP_ALLOC, nbytes, ffha_pkg::ADDR_W'($urandom()));
  endtask

  task automatic request_free(input logic [ffha_pkg::ADDR_W-1:0] addr);
    send_request(ffha_pkg::OP_FREE, ffha_pkg::SIZE_W'($urandom()), addr);
  endtask

  // Setup then access phase; upper data bits are junk the block must drop.
  // An idle wait afterwards keeps back-to-back writes from toggling psel
  // twice in one step.
  task automatic write_reg(input logic idx, input logic [ffha_pkg::SIZE_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ffha_pkg::CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= {(ffha_pkg::CFG_DW - ffha_pkg::SIZE_W)'($urandom()), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, then wait for every predicted result plus a tail.
  // The first edge lets the checker's pending count catch up.
  task automatic drain_results(input int unsigned tail);
    req_chan.valid <= 1'b0;
    @(posedge clk);
    while (grants_pending != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Mostly well-formed traffic: small allocs and frees of live blocks keep
  // the heap fragmented so walks, splits and reuse get deep. The rest is
  // junk: odd sizes, stray, null, edge-of-heap and double frees.
  task automatic issue_random();
    int unsigned                 pick;
    int unsigned                 idx;
    logic [ffha_pkg::SIZE_W-1:0] nbytes;
    logic [ffha_pkg::ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      nbytes = ffha_pkg::SIZE_W'($urandom_range(1, 48));
      else if (pick < 85) nbytes = ffha_pkg::SIZE_W'($urandom_range(49, 400));
      else if (pick < 90) nbytes = '0;
      else if (pick < 96) nbytes = ffha_pkg::SIZE_W'($urandom_range(401, 4095));
      else                nbytes = 12'hFFF - ffha_pkg::SIZE_W'($urandom_range(0, 2));
      request_alloc(nbytes);
    end else if (pick < 88 && live_blocks.size() > 0) begin
      idx  = $urandom_range(0, live_blocks.size() - 1);
      addr = live_blocks[idx];
      live_blocks.delete(idx);
      recent_free = addr;
      request_free(addr);
    end else begin
      case ($urandom_range(0, 4))
        0: addr = ffha_pkg::ADDR_W'($urandom());
        1: addr = '0;
        2: addr = ffha_pkg::ADDR_W'($urandom_range(1, 2 * ffha_pkg::HEADER_BYTES_DEF));
        3: addr = ffha_pkg::ADDR_W'($urandom_range(
                    ffha_pkg::HEAP_BYTES_DEF - ffha_pkg::HEADER_BYTES_DEF,
                    ffha_pkg::HEAP_BYTES_DEF + ffha_pkg::HEADER_BYTES_DEF));
        default: addr = recent_free;  // double free
      endcase
      request_free(addr);
    end
  endtask

  // Result side: random back-pressure; successful grants feed the free pool
  initial begin : result_sink
    int hold;
    rsp_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = draw_wait(sink_run);
      if (hold > 0) begin
        rsp_chan.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_chan.ready <= 1'b1;
      do @(posedge clk); while (rsp_chan.valid !== 1'b1);
      if (rsp_chan.status == ffha_pkg::ST_OK && rsp_chan.payload_addr != '0)
        live_blocks.push_back(rsp_chan.payload_addr);
    end
  end

  // Watchdog: any request, result or register write resets the count
  always @(posedge clk) begin
    if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
        (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) || cfg_psel)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned thr;
    int unsigned lim;
    int unsigned count;
    rst_n              = 1'b0;
    req_chan.valid     = 1'b0;
    req_chan.op        = ffha_pkg::OP_ALLOC;
    req_chan.req_size  = '0;
    req_chan.free_addr = '0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass at reset settings (split 32, max 4095)
    request_alloc(12'd0);       // zero size
    request_free(13'd0);        // null
    request_free(13'd15);       // below the first header
    request_free(13'd16);       // heap still empty
    request_alloc(12'd4095);    // can never fit: out of memory
    request_alloc(12'd1);       // first append, payload 16
    request_alloc(12'd100);     // payload 33, heap end 133
    request_free(13'd33);
    request_alloc(12'd10);      // 100-byte hole split into 10 + header + 74
    request_alloc(12'd60);      // 74-byte hole: excess under threshold, taken whole
    request_free(13'd33);
    request_free(13'd33);       // double free still ok
    request_alloc(12'd10);      // exact-fit reuse
    request_free(13'd149);      // header slot at heap end: ignored
    request_free(13'd148);      // mid-block offset inside heap: ok
    request_free(13'h1FFF);     // all-ones address
    request_free(13'd4096);
    request_alloc(12'd4080);    // only an empty heap holds this
    request_alloc(12'd2000);    // big append

    // Register phases: split threshold and request limit at both ends
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin thr = 0;    lim = 4095; count = 160; end
        1: begin thr = 4095; lim = 4095; count = 150; end  // never split
        2: begin thr = 16;   lim = 1;    count = 60;  end  // only 1-byte requests fit the limit
        3: begin thr = 7;    lim = 300;  count = 160; end
        4: begin
          thr   = $urandom_range(1, 100);
          lim   = $urandom_range(64, 2000);
          count = 160;
        end
        default: begin thr = 32; lim = 4095; count = 160; end
      endcase
      drain_results(CFG_SETTLE);
      write_reg(ffha_pkg::REG_SPLIT_THR, ffha_pkg::SIZE_W'(thr));
      write_reg(ffha_pkg::REG_MAX_REQ, ffha_pkg::SIZE_W'(lim));
      repeat (count) issue_random();
    end

    drain_results(DRAIN_TAIL);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: first_fit_heap_allocator.f
rtl/ffha_pkg.sv
rtl/ffha_if.sv
rtl/first_fit_heap_allocator.sv
sim/ffha_checker.sv
sim/tb_top.sv
